@@ design/wsm_pkg.sv @@
// shared widths, register indexes and input codes for the window stability median block
package wsm_pkg;

    // store depth
    localparam int MAX_WINDOW = 64;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int FILL_W     = 7;
    localparam int TOL_W      = 16;
    localparam int WSIZE_W    = 7;
    localparam int BIT_IDX_W  = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd64;
    localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b1;

    // input mode codes
    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // sample constants
    localparam logic [SAMPLE_W-1:0]  SAMPLE_ONES = 16'hFFFF;
    localparam logic [BIT_IDX_W-1:0] TOP_BIT     = 4'd15;

endpackage

@@ design/window_stability_median.sv @@
// sliding window median with spread check: sample store, radix select sequencer, config regs
//
// Usage: an input beat (mode, sample) is taken when in_valid is high and in_stall is low.
// mode pushes the sample into a circular store of window_size entries or clears the window.
// Each input beat yields exactly one output beat (stable, middle_value, fill_count), offered
// on out_valid and taken when out_stall is low.
// A push scans the n filled entries, n being the fill count after the push; a clear skips
// the scan. The sample store has a single read port, so the median is found by a
// bitwise radix select that reads every valid entry once per sample bit, and the min/max
// spread scan rides along in the first of those passes. One beat is in work at a time;
// in_stall is high from accept until the result sits in the output register.
// Receiver stall: a finished result waits in the output register, and the next input beat
// is accepted meanwhile; the block holds a new result until that register is free.
// Reset: fill count and write position go to zero, tolerance to 0, window_size to 64; the
// sample store is not cleared and needs no clearing pass. Configuration writes on
// cfg_wr_en take effect at once and belong only where no beat is in work.
module window_stability_median (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [wsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wsm_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic [wsm_pkg::SAMPLE_W-1:0]     sample,
    // output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             stable,
    output logic [wsm_pkg::SAMPLE_W-1:0]     middle_value,
    output logic [wsm_pkg::FILL_W-1:0]       fill_count
);

    localparam int ADDR_W = (wsm_pkg::MAX_WINDOW > 1) ? $clog2(wsm_pkg::MAX_WINDOW) : 1;
    localparam int CW     = (ADDR_W + 1 > wsm_pkg::FILL_W) ? ADDR_W + 1 : wsm_pkg::FILL_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                            state_reg;
    logic [wsm_pkg::TOL_W-1:0]         tolerance_reg;
    logic [wsm_pkg::WSIZE_W-1:0]       window_size_reg;
    logic [ADDR_W-1:0]                 write_pos_reg;
    logic [wsm_pkg::FILL_W-1:0]        filled_reg;
    logic [wsm_pkg::FILL_W-1:0]        n_reg;
    logic                              check_reg;
    logic [CW-1:0]                     rd_idx_reg;
    logic                              rd_vld_reg;
    logic [wsm_pkg::SAMPLE_W-1:0]      rd_data_reg;
    logic [wsm_pkg::BIT_IDX_W-1:0]     bit_reg;
    logic [wsm_pkg::SAMPLE_W-1:0]      prefix_reg;
    logic [wsm_pkg::FILL_W-1:0]        rank_reg;
    logic [wsm_pkg::FILL_W-1:0]        cnt_reg;
    logic [wsm_pkg::SAMPLE_W-1:0]      lo_reg;
    logic [wsm_pkg::SAMPLE_W-1:0]      hi_reg;
    logic                              stable_res_reg;
    logic                              out_valid_reg;
    logic                              stable_reg;
    logic [wsm_pkg::SAMPLE_W-1:0]      middle_value_reg;
    logic [wsm_pkg::FILL_W-1:0]        fill_count_reg;

    logic [wsm_pkg::SAMPLE_W-1:0]      store_mem [wsm_pkg::MAX_WINDOW];

    logic                              in_acc;
    logic                              out_free;
    logic                              do_push;
    logic [CW-1:0]                     ws_ext;
    logic [CW-1:0]                     size_eff;
    logic [CW-1:0]                     pos_inc;
    logic [ADDR_W-1:0]                 write_pos_next;
    logic [wsm_pkg::FILL_W-1:0]        filled_next;
    logic [wsm_pkg::FILL_W-1:0]        n_next;
    logic                              check_next;
    logic                              issuing;
    logic                              pass_end;
    logic [ADDR_W-1:0]                 rd_addr;
    logic [4:0]                        shamt;
    logic [wsm_pkg::SAMPLE_W-1:0]      upper_mask;
    logic                              hit;
    logic [wsm_pkg::FILL_W-1:0]        cnt_sum;
    logic                              take_one;
    logic [wsm_pkg::SAMPLE_W-1:0]      lo_c;
    logic [wsm_pkg::SAMPLE_W-1:0]      hi_c;
    logic [wsm_pkg::SAMPLE_W-1:0]      spread;

    // handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign do_push   = in_acc && (mode == wsm_pkg::MODE_PUSH);

    // effective window size, clamped to one up to the store depth
    assign ws_ext   = CW'(window_size_reg);
    assign size_eff = (window_size_reg == '0) ? CW'(1) :
                      ((ws_ext > CW'(wsm_pkg::MAX_WINDOW)) ? CW'(wsm_pkg::MAX_WINDOW) : ws_ext);

    // write position and fill count after a push or clear
    always_comb
    begin
        pos_inc        = CW'(write_pos_reg) + CW'(1);
        write_pos_next = (pos_inc >= size_eff) ? '0 : pos_inc[ADDR_W-1:0];
        if (mode == wsm_pkg::MODE_CLEAR)
        begin
            filled_next = '0;
        end
        else if (CW'(filled_reg) < size_eff)
        begin
            filled_next = filled_reg + wsm_pkg::FILL_W'(1);
        end
        else
        begin
            filled_next = filled_reg;
        end
        n_next     = (CW'(filled_next) < size_eff) ? filled_next : size_eff[wsm_pkg::FILL_W-1:0];
        check_next = (CW'(filled_next) >= size_eff);
    end

    // read sequencing over entries 0..n-1
    assign issuing  = (state_reg == ST_SCAN) && (rd_idx_reg < CW'(n_reg));
    assign pass_end = (state_reg == ST_SCAN) && (rd_idx_reg == CW'(n_reg));
    assign rd_addr  = rd_idx_reg[ADDR_W-1:0];

    // shared compare unit: prefix match and bit test, plus min/max tracking
    always_comb
    begin
        shamt      = {1'b0, bit_reg} + 5'd1;
        upper_mask = wsm_pkg::SAMPLE_ONES << shamt;
        hit        = rd_vld_reg && (((rd_data_reg ^ prefix_reg) & upper_mask) == '0)
                     && !rd_data_reg[bit_reg];
        cnt_sum    = cnt_reg + wsm_pkg::FILL_W'(hit);
        take_one   = (rank_reg >= cnt_sum);
        lo_c       = (rd_vld_reg && (rd_data_reg < lo_reg)) ? rd_data_reg : lo_reg;
        hi_c       = (rd_vld_reg && (rd_data_reg > hi_reg)) ? rd_data_reg : hi_reg;
        spread     = hi_c - lo_c;
    end

    // sample store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_mem[write_pos_reg] <= sample;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // sequencer, window state, config registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            tolerance_reg    <= wsm_pkg::TOL_RESET;
            window_size_reg  <= wsm_pkg::WSIZE_RESET;
            write_pos_reg    <= '0;
            filled_reg       <= '0;
            rd_idx_reg       <= '0;
            rd_vld_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            n_reg            <= '0;
            check_reg        <= 1'b0;
            bit_reg          <= '0;
            prefix_reg       <= '0;
            rank_reg         <= '0;
            cnt_reg          <= '0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            stable_res_reg   <= 1'b0;
            stable_reg       <= 1'b0;
            middle_value_reg <= '0;
            fill_count_reg   <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    wsm_pkg::REG_TOLERANCE:   tolerance_reg   <= cfg_wr_data;
                    wsm_pkg::REG_WINDOW_SIZE: window_size_reg <= cfg_wr_data[wsm_pkg::WSIZE_W-1:0];
                    default: ;
                endcase
            end

            // output register loads a finished result and drains when taken
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            rd_vld_reg <= issuing;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        filled_reg     <= filled_next;
                        n_reg          <= n_next;
                        check_reg      <= check_next;
                        rd_idx_reg     <= '0;
                        cnt_reg        <= '0;
                        prefix_reg     <= '0;
                        bit_reg        <= wsm_pkg::TOP_BIT;
                        rank_reg       <= n_next >> 1;
                        lo_reg         <= wsm_pkg::SAMPLE_ONES;
                        hi_reg         <= '0;
                        stable_res_reg <= 1'b0;
                        if (mode == wsm_pkg::MODE_CLEAR)
                        begin
                            write_pos_reg <= '0;
                            state_reg     <= ST_FINISH;
                        end
                        else
                        begin
                            write_pos_reg <= write_pos_next;
                            state_reg     <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (pass_end)
                    begin
                        // settle one median bit per pass
                        rd_idx_reg <= '0;
                        cnt_reg    <= '0;
                        if (take_one)
                        begin
                            prefix_reg <= prefix_reg | (wsm_pkg::SAMPLE_W'(1) << bit_reg);
                            rank_reg   <= rank_reg - cnt_sum;
                        end
                        if (bit_reg == wsm_pkg::TOP_BIT)
                        begin
                            stable_res_reg <= check_reg && (spread <= tolerance_reg);
                        end
                        if (bit_reg == '0)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            bit_reg <= bit_reg - wsm_pkg::BIT_IDX_W'(1);
                        end
                    end
                    else
                    begin
                        if (issuing)
                        begin
                            rd_idx_reg <= rd_idx_reg + CW'(1);
                        end
                        cnt_reg <= cnt_sum;
                        lo_reg  <= lo_c;
                        hi_reg  <= hi_c;
                    end
                end
                ST_FINISH:
                begin
                    // hand the result to the output register once it is free
                    if (out_free)
                    begin
                        stable_reg       <= stable_res_reg;
                        middle_value_reg <= prefix_reg;
                        fill_count_reg   <= n_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign stable       = stable_reg;
    assign middle_value = middle_value_reg;
    assign fill_count   = fill_count_reg;

    // an accepted beat always starts work
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != ST_IDLE)
        else $error("accepted beat did not leave idle");

    // read counter never runs past the fill count
    a_rd_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> rd_idx_reg <= CW'(n_reg))
        else $error("read index beyond fill count");

    // a scan only runs on a non-empty window
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> n_reg != '0)
        else $error("scan started on empty window");

    // a stable result implies a non-empty window
    a_stable_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stable |-> fill_count != '0)
        else $error("stable reported with empty window");

    // fill count never exceeds the store depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> CW'(fill_count) <= CW'(wsm_pkg::MAX_WINDOW))
        else $error("fill count beyond store depth");

endmodule

@@ test/wsm_result_checker.sv @@
// result checker for window_stability_median: tracks the window and compares every output beat
module wsm_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [wsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wsm_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           mode,
    input  logic [wsm_pkg::SAMPLE_W-1:0]   sample,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           stable,
    input  logic [wsm_pkg::SAMPLE_W-1:0]   middle_value,
    input  logic [wsm_pkg::FILL_W-1:0]     fill_count,
    output int                             mismatches,
    output int                             outstanding
);

    typedef struct packed {
        logic                         stable;
        logic [wsm_pkg::SAMPLE_W-1:0] middle;
        logic [wsm_pkg::FILL_W-1:0]   count;
    } window_report_t;

    // own copy of the window contents and the registers
    logic [wsm_pkg::SAMPLE_W-1:0] samples_held [wsm_pkg::MAX_WINDOW];
    int                           next_slot = 0;
    int                           held_count = 0;
    logic [wsm_pkg::TOL_W-1:0]    spread_limit = wsm_pkg::TOL_RESET;
    logic [wsm_pkg::WSIZE_W-1:0]  size_reg = wsm_pkg::WSIZE_RESET;

    window_report_t               reports_due [$];
    window_report_t               due;

    // apply one input beat to the window and work out the report it yields
    function automatic window_report_t apply_beat(input logic op,
                                                  input logic [wsm_pkg::SAMPLE_W-1:0] value);
        window_report_t               rep;
        logic [wsm_pkg::SAMPLE_W-1:0] ordered [wsm_pkg::MAX_WINDOW];
        logic [wsm_pkg::SAMPLE_W-1:0] lo;
        logic [wsm_pkg::SAMPLE_W-1:0] hi;
        logic [wsm_pkg::SAMPLE_W-1:0] key;
        int                           span;
        int                           n;
        int                           j;

        // window size clamped to one up to the store depth
        if (size_reg == '0)
            span = 1;
        else if (int'(size_reg) > wsm_pkg::MAX_WINDOW)
            span = wsm_pkg::MAX_WINDOW;
        else
            span = int'(size_reg);

        if (op == wsm_pkg::MODE_CLEAR)
        begin
            next_slot = 0;
            held_count = 0;
        end
        else
        begin
            if (next_slot >= wsm_pkg::MAX_WINDOW)
                next_slot = 0;
            samples_held[next_slot] = value;
            next_slot = (next_slot + 1 >= span) ? 0 : next_slot + 1;
            if (held_count < span)
                held_count++;
        end

        n = (held_count < span) ? held_count : span;
        rep.stable = 1'b0;
        rep.middle = '0;
        rep.count = n[wsm_pkg::FILL_W-1:0];

        // spread check over the whole window once it is full
        if (held_count >= span)
        begin
            lo = samples_held[0];
            hi = samples_held[0];
            for (int i = 1; i < span; i++)
            begin
                if (samples_held[i] < lo)
                    lo = samples_held[i];
                if (samples_held[i] > hi)
                    hi = samples_held[i];
            end
            rep.stable = ((hi - lo) <= spread_limit);
        end

        // sort the filled entries and take the upper middle one
        for (int i = 0; i < n; i++)
        begin
            key = samples_held[i];
            j = i;
            while (j > 0 && ordered[j-1] > key)
            begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = key;
        end
        if (n > 0)
            rep.middle = ordered[n/2];
        return rep;
    endfunction

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_slot = 0;
            held_count = 0;
            spread_limit = wsm_pkg::TOL_RESET;
            size_reg = wsm_pkg::WSIZE_RESET;
            reports_due.delete();
            outstanding <= 0;
        end
        else
        begin
            // output beat against the oldest report due
            if (out_valid && !out_stall)
            begin
                if (reports_due.size() == 0)
                begin
                    $display("%0t: output beat with no report due: stable %0d middle %0d count %0d",
                             $time, stable, middle_value, fill_count);
                    mismatches++;
                end
                else
                begin
                    due = reports_due.pop_front();
                    if (stable !== due.stable)
                    begin
                        $display("%0t: stable expected %0d actual %0d",
                                 $time, due.stable, stable);
                        mismatches++;
                    end
                    if (middle_value !== due.middle)
                    begin
                        $display("%0t: middle_value expected %0d actual %0d",
                                 $time, due.middle, middle_value);
                        mismatches++;
                    end
                    if (fill_count !== due.count)
                    begin
                        $display("%0t: fill_count expected %0d actual %0d",
                                 $time, due.count, fill_count);
                        mismatches++;
                    end
                end
            end

            // input beat
            if (in_valid && !in_stall)
                reports_due.push_back(apply_beat(mode, sample));

            // register writes
            if (cfg_wr_en)
            begin
                if (cfg_index == wsm_pkg::REG_TOLERANCE)
                    spread_limit = cfg_wr_data[wsm_pkg::TOL_W-1:0];
                else if (cfg_index == wsm_pkg::REG_WINDOW_SIZE)
                    size_reg = cfg_wr_data[wsm_pkg::WSIZE_W-1:0];
            end

            outstanding <= reports_due.size();
        end
    end

endmodule

@@ test/tb_window_stability_median.sv @@
// testbench top for window_stability_median: reset, stimulus, receiver stalls and verdict
module tb_window_stability_median;

    localparam int ITEM_TARGET   = 1700;
    localparam int HOLD_CYCLES   = 2500;
    localparam int SETTLE_CYCLES = 1100;
    localparam int HOLD_PHASE    = 12;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [wsm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [wsm_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           mode = wsm_pkg::MODE_PUSH;
    logic [wsm_pkg::SAMPLE_W-1:0]   sample = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic                           stable;
    logic [wsm_pkg::SAMPLE_W-1:0]   middle_value;
    logic [wsm_pkg::FILL_W-1:0]     fill_count;
    int                             mismatches;
    int                             outstanding;

    int                             beats_sent = 0;
    int                             send_idle_pct = 0;
    int                             recv_idle_pct = 0;
    logic                           hold_off = 1'b0;
    logic                           hold_req = 1'b0;

    // sample clustering for the current phase
    logic [wsm_pkg::SAMPLE_W-1:0]   cluster_base = '0;
    int                             cluster_spread = 0;

    always #1 clk = ~clk;

    window_stability_median dut (.*);

    wsm_result_checker report_check (.*);

    // receiver: random stall plus the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // long receiver hold-off while the sender keeps offering beats
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #20000000;
        $display("window_stability_median regression: fail");
        $finish;
    end

    // offer one beat and hold it until it is taken
    task automatic send_beat(input logic op, input logic [wsm_pkg::SAMPLE_W-1:0] value);
        if (beats_sent < ITEM_TARGET / 3)
        begin
            send_idle_pct = 10;
            recv_idle_pct <= 60;
        end
        else if (beats_sent < 2 * ITEM_TARGET / 3)
        begin
            send_idle_pct = 60;
            recv_idle_pct <= 10;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        sample   <= value;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
    endtask

    // stop sending until every report has come back
    task automatic wait_for_reports();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [wsm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wsm_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // registers change only with the block idle
    task automatic reconfigure(input logic [wsm_pkg::TOL_W-1:0] tol,
                               input logic [wsm_pkg::WSIZE_W-1:0] wsize);
        wait_for_reports();
        write_reg(wsm_pkg::REG_TOLERANCE, wsm_pkg::CFG_DATA_W'(tol));
        write_reg(wsm_pkg::REG_WINDOW_SIZE, wsm_pkg::CFG_DATA_W'(wsize));
    endtask

    // mostly close to the phase base, now and then anywhere
    function automatic logic [wsm_pkg::SAMPLE_W-1:0] clustered_sample();
        if ($urandom_range(99) < 5)
            return wsm_pkg::SAMPLE_W'($urandom);
        return cluster_base + wsm_pkg::SAMPLE_W'($urandom_range(0, cluster_spread));
    endfunction

    initial
    begin
        int                          size_pick;
        int                          phase_len;
        int                          phase;
        int                          big_phases;
        logic [wsm_pkg::TOL_W-1:0]   tol_pick;
        logic [wsm_pkg::WSIZE_W-1:0] size_val;

        phase = 0;
        big_phases = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, duplicates and clears at the reset settings
        send_beat(wsm_pkg::MODE_PUSH, '0);
        send_beat(wsm_pkg::MODE_PUSH, wsm_pkg::SAMPLE_ONES);
        send_beat(wsm_pkg::MODE_PUSH, 16'h8000);
        send_beat(wsm_pkg::MODE_PUSH, 16'h7FFF);
        send_beat(wsm_pkg::MODE_PUSH, 16'h5555);
        send_beat(wsm_pkg::MODE_PUSH, 16'hAAAA);
        send_beat(wsm_pkg::MODE_CLEAR, 16'h1234);
        send_beat(wsm_pkg::MODE_CLEAR, wsm_pkg::SAMPLE_ONES);
        send_beat(wsm_pkg::MODE_PUSH, 16'h0001);
        send_beat(wsm_pkg::MODE_PUSH, 16'h0001);
        send_beat(wsm_pkg::MODE_PUSH, '0);

        // fill every store entry with a tight cluster, then break it with an outlier
        reconfigure(16'd3, 7'd64);
        cluster_base = wsm_pkg::SAMPLE_W'($urandom);
        send_beat(wsm_pkg::MODE_CLEAR, '0);
        repeat (66)
            send_beat(wsm_pkg::MODE_PUSH,
                      cluster_base + wsm_pkg::SAMPLE_W'($urandom_range(0, 3)));
        send_beat(wsm_pkg::MODE_PUSH, cluster_base ^ 16'h8000);
        send_beat(wsm_pkg::MODE_PUSH, cluster_base);

        // size zero acts as one, changed without a clear
        reconfigure(wsm_pkg::TOL_RESET, 7'd0);
        send_beat(wsm_pkg::MODE_PUSH, wsm_pkg::SAMPLE_ONES);
        send_beat(wsm_pkg::MODE_PUSH, '0);

        // size above the store depth acts as the full depth
        reconfigure(16'd0, 7'd127);
        send_beat(wsm_pkg::MODE_PUSH, 16'h00FF);
        reconfigure(16'hFFFF, 7'd127);
        send_beat(wsm_pkg::MODE_PUSH, '0);

        // two entry window: stable only on equal samples at zero tolerance
        reconfigure(16'd0, 7'd2);
        send_beat(wsm_pkg::MODE_CLEAR, '0);
        send_beat(wsm_pkg::MODE_PUSH, 16'h0042);
        send_beat(wsm_pkg::MODE_PUSH, 16'h0042);
        send_beat(wsm_pkg::MODE_PUSH, 16'h0043);

        // grow the window without a clear
        reconfigure(16'd1, wsm_pkg::WSIZE_RESET);
        send_beat(wsm_pkg::MODE_PUSH, 16'h0044);

        // random phases, mostly small windows and a few large ones
        while (beats_sent < ITEM_TARGET)
        begin
            phase++;
            size_pick = $urandom_range(99);
            if (size_pick < 8 && big_phases < 3)
            begin
                big_phases++;
                size_val = wsm_pkg::WSIZE_W'($urandom_range(63, 127));
                phase_len = $urandom_range(66, 80);
            end
            else
            begin
                if (size_pick < 70)
                    size_val = wsm_pkg::WSIZE_W'($urandom_range(0, 8));
                else
                    size_val = wsm_pkg::WSIZE_W'($urandom_range(9, 24));
                phase_len = $urandom_range(30, 90);
            end

            case ($urandom_range(3))
                0: tol_pick = '0;
                1: tol_pick = '1;
                2: tol_pick = wsm_pkg::TOL_W'($urandom_range(0, 32));
                default: tol_pick = wsm_pkg::TOL_W'($urandom);
            endcase

            case ($urandom_range(3))
                0: cluster_spread = 0;
                1: cluster_spread = $urandom_range(1, 16);
                2: cluster_spread = $urandom_range(17, 600);
                default: cluster_spread = 65535;
            endcase
            cluster_base = wsm_pkg::SAMPLE_W'($urandom);

            reconfigure(tol_pick, size_val);
            if (phase == HOLD_PHASE)
                hold_req = 1'b1;

            // usually start from an empty window, otherwise keep the old contents
            if ($urandom_range(3) != 0)
                send_beat(wsm_pkg::MODE_CLEAR, wsm_pkg::SAMPLE_W'($urandom));
            repeat (phase_len)
            begin
                if ($urandom_range(99) < 3)
                    send_beat(wsm_pkg::MODE_CLEAR, wsm_pkg::SAMPLE_W'($urandom));
                else
                    send_beat(wsm_pkg::MODE_PUSH, clustered_sample());
            end
        end

        wait_for_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("window_stability_median regression: pass");
        else
            $display("window_stability_median regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
design/wsm_pkg.sv
design/window_stability_median.sv
test/wsm_result_checker.sv
test/tb_window_stability_median.sv
